// File: hdl/hrhp_pkg.sv
// Package with the types, constants and character tables of the HTTP response header parser.
`default_nettype none

package hrhp_pkg;

  localparam int unsigned PREFIX_LEN = 9;
  localparam int unsigned MIN_LEN    = 12;
  localparam int unsigned KW_LEN     = 16;

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LC_C  = 8'h63;

  typedef enum logic [1:0] {
    OUT_OK         = 2'd0,
    OUT_INVALID    = 2'd1,
    OUT_INCOMPLETE = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    NP_IDLE  = 2'd0,
    NP_SKIP  = 2'd1,
    NP_BEGUN = 2'd2,
    NP_DONE  = 2'd3
  } num_phase_e;

  typedef struct packed {
    num_phase_e phase;
    logic       neg;
  } num_state_t;

  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h48;
      4'd1:    c = 8'h54;
      4'd2:    c = 8'h54;
      4'd3:    c = 8'h50;
      4'd4:    c = 8'h2F;
      4'd5:    c = 8'h31;
      4'd6:    c = 8'h2E;
      4'd7:    c = 8'h31;
      4'd8:    c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] keyword_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h63;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h6E;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6E;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2D;
      4'd8:    c = 8'h6C;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6E;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      4'd14:   c = 8'h3A;
      4'd15:   c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/hrhp_if.sv
// Interfaces for the byte input channel and the result channel of the header parser.
`default_nettype none

interface hrhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface hrhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  outcome;
  logic [15:0] status_code;
  logic [31:0] hdr_bytes;
  logic [31:0] body_bytes;
  logic [31:0] total_length;

  modport source (output valid, output outcome, output status_code, output hdr_bytes,
                  output body_bytes, output total_length, input ready);
  modport sink   (input valid, input outcome, input status_code, input hdr_bytes,
                  input body_bytes, input total_length, output ready);
endinterface

`default_nettype wire

// File: hdl/http_response_header_parser.sv
// Top level of the streaming HTTP/1.x response header parser.
`default_nettype none

// The parser takes one response byte per item, one item every clock cycle while
// the input side does not stall, and gives a single result item for each final byte.
// Each byte passes an input register and then updates the scan state in the
// same cycle; the final byte also forms the result, which lands in an output
// register. The input side stalls only when a final byte meets an output
// register whose result has not yet been taken; all scan state clears after
// each final byte, ready for the next message.
module http_response_header_parser #(
  parameter int unsigned COUNT_BITS = 32
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  hrhp_in_if.sink  in_i,
  hrhp_out_if.source out_o
);
  import hrhp_pkg::*;

  logic                  s1_valid_q;
  logic [7:0]            s1_byte_q;
  logic                  s1_fin_q;
  logic                  out_free;
  logic                  adv;
  logic                  accept;

  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  prefix_ok_q, prefix_ok_d;
  num_state_t            sst_q, sst_d;
  logic [15:0]           sval_q, sval_d;
  logic [1:0]            term_q, term_d;
  logic                  seen_q, seen_d;
  logic [COUNT_BITS-1:0] hpos_q, hpos_d;
  logic [3:0]            kw_q, kw_d;
  num_state_t            lst_q, lst_d, lst_kw, lst_num;
  logic [31:0]           lval_q, lval_d;

  logic                  out_valid_q;
  logic [1:0]            outcome_q, outcome_d;
  logic [15:0]           status_q, status_d;
  logic [31:0]           hlen_q, hlen_d;
  logic [31:0]           clen_q, clen_d;
  logic [31:0]           total_q, total_d;

  logic [7:0]            b;
  logic [7:0]            lo;
  logic [COUNT_BITS-1:0] idx_inc;
  logic                  in_prefix;
  logic [31:0]           clen_decl;
  logic [32:0]           need;
  logic                  total_ge_h;

  assign b         = s1_byte_q;
  assign out_free  = !out_valid_q || out_o.ready;
  assign adv       = s1_valid_q && (!s1_fin_q || out_free);
  assign in_i.ready = !s1_valid_q || adv;
  assign accept    = in_i.valid && in_i.ready;
  assign idx_inc   = (count_q == '1) ? count_q : count_q + 1'b1;
  assign in_prefix = count_q < COUNT_BITS'(PREFIX_LEN);
  assign lo        = ((b >= CHAR_UC_A) && (b <= CHAR_UC_Z)) ? (b | 8'h20) : b;

  hrhp_num_step #(.W(16)) u_status (
    .en_i   (!in_prefix),
    .byte_i (b),
    .st_i   (sst_q),
    .val_i  (sval_q),
    .st_o   (sst_d),
    .val_o  (sval_d)
  );

  hrhp_num_step #(.W(32)) u_length (
    .en_i   (1'b1),
    .byte_i (b),
    .st_i   (lst_q),
    .val_i  (lval_q),
    .st_o   (lst_num),
    .val_o  (lval_d)
  );

  always_comb begin
    count_d     = idx_inc;
    prefix_ok_d = prefix_ok_q;
    if (in_prefix) begin
      if (!((b == prefix_char(count_q[3:0])) ||
            ((count_q == COUNT_BITS'(7)) && (b == CHAR_ZERO)))) begin
        prefix_ok_d = 1'b0;
      end
    end

    term_d = term_q;
    seen_d = seen_q;
    hpos_d = hpos_q;
    if (!seen_q) begin
      if (b == (((term_q == 2'd0) || (term_q == 2'd2)) ? CHAR_CR : CHAR_LF)) begin
        if (term_q == 2'd3) begin
          seen_d = 1'b1;
          hpos_d = idx_inc;
          term_d = 2'd0;
        end else begin
          term_d = term_q + 2'd1;
        end
      end else begin
        term_d = (b == CHAR_CR) ? 2'd1 : 2'd0;
      end
    end

    kw_d   = kw_q;
    lst_kw = lst_q;
    if (lst_q.phase == NP_IDLE) begin
      if (lo == keyword_char(kw_q)) begin
        if (kw_q == 4'(KW_LEN - 1)) begin
          kw_d         = 4'd0;
          lst_kw.phase = NP_SKIP;
        end else begin
          kw_d = kw_q + 4'd1;
        end
      end else begin
        kw_d = (lo == CHAR_LC_C) ? 4'd1 : 4'd0;
      end
    end
    lst_d = (lst_q.phase == NP_IDLE) ? lst_kw : lst_num;
  end

  always_comb begin
    total_d    = 32'(count_d);
    status_d   = 16'd0;
    hlen_d     = 32'd0;
    clen_d     = 32'd0;
    outcome_d  = OUT_INVALID;
    clen_decl  = 32'd0;
    total_ge_h = count_d >= hpos_d;
    if (lst_d.phase != NP_IDLE) begin
      clen_decl = lst_d.neg ? (~lval_d + 32'd1) : lval_d;
    end
    need = {1'b0, clen_decl} + 33'(hpos_d);
    if ((count_d >= COUNT_BITS'(MIN_LEN)) && prefix_ok_d && seen_d) begin
      status_d = (sst_d.neg && (sval_d != 16'd0)) ? 16'hFFFF : sval_d;
      hlen_d   = 32'(hpos_d);
      if (clen_decl == 32'd0) begin
        clen_d    = total_ge_h ? 32'(count_d - hpos_d) : 32'd0;
        outcome_d = total_ge_h ? OUT_OK : OUT_INCOMPLETE;
      end else begin
        clen_d    = clen_decl;
        outcome_d = (33'(count_d) >= need) ? OUT_OK : OUT_INCOMPLETE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q <= in_i.data_byte;
      s1_fin_q  <= in_i.final_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      prefix_ok_q <= 1'b1;
      sst_q       <= '{phase: NP_SKIP, neg: 1'b0};
      sval_q      <= '0;
      term_q      <= '0;
      seen_q      <= 1'b0;
      hpos_q      <= '0;
      kw_q        <= '0;
      lst_q       <= '{phase: NP_IDLE, neg: 1'b0};
      lval_q      <= '0;
    end else if (adv) begin
      if (s1_fin_q) begin
        count_q     <= '0;
        prefix_ok_q <= 1'b1;
        sst_q       <= '{phase: NP_SKIP, neg: 1'b0};
        sval_q      <= '0;
        term_q      <= '0;
        seen_q      <= 1'b0;
        hpos_q      <= '0;
        kw_q        <= '0;
        lst_q       <= '{phase: NP_IDLE, neg: 1'b0};
        lval_q      <= '0;
      end else begin
        count_q     <= count_d;
        prefix_ok_q <= prefix_ok_d;
        sst_q       <= sst_d;
        sval_q      <= sval_d;
        term_q      <= term_d;
        seen_q      <= seen_d;
        hpos_q      <= hpos_d;
        kw_q        <= kw_d;
        lst_q       <= lst_d;
        lval_q      <= lval_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && s1_fin_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_fin_q) begin
      outcome_q <= outcome_d;
      status_q  <= status_d;
      hlen_q    <= hlen_d;
      clen_q    <= clen_d;
      total_q   <= total_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.outcome      = outcome_q;
  assign out_o.status_code  = status_q;
  assign out_o.hdr_bytes    = hlen_q;
  assign out_o.body_bytes   = clen_q;
  assign out_o.total_length = total_q;

endmodule

`default_nettype wire

// File: hdl/hrhp_num_step.sv
// Decimal number decoder step: skips whitespace, takes one sign and accumulates digits.
`default_nettype none

module hrhp_num_step #(
  parameter int unsigned W = 32
) (
  input  wire logic                  en_i,
  input  wire logic [7:0]            byte_i,
  input  wire hrhp_pkg::num_state_t  st_i,
  input  wire logic [W-1:0]          val_i,
  output      hrhp_pkg::num_state_t  st_o,
  output      logic [W-1:0]          val_o
);
  import hrhp_pkg::*;

  logic         is_digit;
  logic         is_space;
  logic         is_sign;
  logic [W+3:0] prod;

  assign is_digit = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
  assign is_space = (byte_i == CHAR_SPACE) || ((byte_i >= CHAR_TAB) && (byte_i <= CHAR_CR));
  assign is_sign  = (byte_i == CHAR_PLUS) || (byte_i == CHAR_MINUS);
  assign prod     = {1'b0, val_i, 3'b000} + {3'b000, val_i, 1'b0}
                  + (W+4)'(byte_i - CHAR_ZERO);

  always_comb begin
    st_o  = st_i;
    val_o = val_i;
    if (en_i && (st_i.phase != NP_IDLE) && (st_i.phase != NP_DONE)) begin
      if (is_digit) begin
        val_o      = (prod[W+3:W] != 4'd0) ? '1 : prod[W-1:0];
        st_o.phase = NP_BEGUN;
      end else if ((st_i.phase != NP_BEGUN) && is_space) begin
        st_o = st_i;
      end else if ((st_i.phase != NP_BEGUN) && is_sign) begin
        st_o.neg   = (byte_i == CHAR_MINUS);
        st_o.phase = NP_BEGUN;
      end else begin
        st_o.phase = NP_DONE;
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/http_response_header_parser_checker.sv
// Checker that predicts every parser result from the accepted bytes and compares it.
`timescale 1ns / 1ps

module http_response_header_parser_checker #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  hrhp_in_if   in_w,
  hrhp_out_if  out_w,
  output int   fail_count,
  output int   pending_count
);
  import hrhp_pkg::*;

  typedef struct packed {
    num_phase_e  phase;
    logic        neg;
    logic [31:0] val;
  } number_scan_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [15:0] status_code;
    logic [31:0] hdr_bytes;
    logic [31:0] body_bytes;
    logic [31:0] total_length;
  } response_summary_t;

  localparam logic [71:0]  VERSION_TEXT = "HTTP/1.1 ";
  localparam logic [127:0] KEYWORD_TEXT = "content-length: ";
  localparam logic [31:0]  COUNT_MAX    = 32'((64'd1 << COUNT_BITS) - 64'd1);
  localparam logic [31:0]  STATUS_MAX   = 32'd65535;
  localparam logic [31:0]  LENGTH_MAX   = 32'hFFFF_FFFF;

  logic [31:0]       seen_bytes;
  logic              version_ok;
  number_scan_t      status_scan;
  logic [1:0]        crlf_progress;
  logic              header_done;
  logic [31:0]       hdr_stop;
  logic [4:0]        keyword_match;
  logic              length_found;
  number_scan_t      length_scan;
  response_summary_t pending_responses[$];

  function automatic logic [31:0] bump_count(logic [31:0] v);
    return (v >= COUNT_MAX) ? COUNT_MAX : v + 32'd1;
  endfunction

  function automatic number_scan_t advance_number(number_scan_t s, logic [7:0] b,
                                                  logic [31:0] limit);
    logic [63:0]  n;
    number_scan_t t;
    t = s;
    if (s.phase == NP_DONE) return t;
    if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
      n = 64'(s.val) * 64'd10 + 64'(b - CHAR_ZERO);
      t.val = (n > 64'(limit)) ? limit : n[31:0];
      t.phase = NP_BEGUN;
    end else if (s.phase != NP_BEGUN && (b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR))) begin
    end else if (s.phase != NP_BEGUN && (b == CHAR_PLUS || b == CHAR_MINUS)) begin
      t.neg = (b == CHAR_MINUS);
      t.phase = NP_BEGUN;
    end else begin
      t.phase = NP_DONE;
    end
    return t;
  endfunction

  task automatic clear_scan();
    seen_bytes    = '0;
    version_ok    = 1'b1;
    status_scan   = '{phase: NP_IDLE, neg: 1'b0, val: '0};
    crlf_progress = '0;
    header_done   = 1'b0;
    hdr_stop      = '0;
    keyword_match = '0;
    length_found  = 1'b0;
    length_scan   = '{phase: NP_IDLE, neg: 1'b0, val: '0};
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    logic [31:0]       pos;
    logic [7:0]        want;
    logic [7:0]        lower;
    logic [31:0]       clen;
    response_summary_t r;
    pos = seen_bytes;
    if (pos < PREFIX_LEN) begin
      if (b != VERSION_TEXT[8*(PREFIX_LEN-1-pos) +: 8] && !(pos == 7 && b == CHAR_ZERO))
        version_ok = 1'b0;
    end else begin
      status_scan = advance_number(status_scan, b, STATUS_MAX);
    end

    if (!header_done) begin
      want = (crlf_progress == 2'd0 || crlf_progress == 2'd2) ? CHAR_CR : CHAR_LF;
      if (b == want) begin
        if (crlf_progress == 2'd3) begin
          header_done   = 1'b1;
          hdr_stop      = bump_count(pos);
          crlf_progress = 2'd0;
        end else begin
          crlf_progress = crlf_progress + 2'd1;
        end
      end else begin
        crlf_progress = (b == CHAR_CR) ? 2'd1 : 2'd0;
      end
    end

    if (length_found) begin
      length_scan = advance_number(length_scan, b, LENGTH_MAX);
    end else begin
      lower = (b >= CHAR_UC_A && b <= CHAR_UC_Z) ? b + 8'd32 : b;
      if (keyword_match < KW_LEN && lower == KEYWORD_TEXT[8*(KW_LEN-1-keyword_match) +: 8])
        keyword_match = keyword_match + 5'd1;
      else
        keyword_match = (lower == KEYWORD_TEXT[127 -: 8]) ? 5'd1 : 5'd0;
      if (keyword_match >= KW_LEN) begin
        length_found  = 1'b1;
        keyword_match = '0;
      end
    end

    seen_bytes = bump_count(pos);

    if (last) begin
      r = '0;
      r.total_length = seen_bytes;
      if (seen_bytes < MIN_LEN || !version_ok || !header_done) begin
        r.outcome = OUT_INVALID;
      end else begin
        r.status_code = (status_scan.neg && status_scan.val != 0) ? 16'hFFFF
                                                                  : status_scan.val[15:0];
        r.hdr_bytes = hdr_stop;
        clen = '0;
        if (length_found) clen = length_scan.neg ? 32'd0 - length_scan.val : length_scan.val;
        if (clen == 0) begin
          if (seen_bytes >= hdr_stop) begin
            clen = seen_bytes - hdr_stop;
            r.outcome = OUT_OK;
          end else begin
            r.outcome = OUT_INCOMPLETE;
          end
        end else begin
          r.outcome = (64'(seen_bytes) >= 64'(clen) + 64'(hdr_stop)) ? OUT_OK : OUT_INCOMPLETE;
        end
        r.body_bytes = clen;
      end
      pending_responses.push_back(r);
      clear_scan();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    response_summary_t head;
    if (!rst_ni) begin
      clear_scan();
      pending_responses.delete();
      pending_count = 0;
    end else begin
      if (out_w.valid && out_w.ready) begin
        if (pending_responses.size() == 0) begin
          $display("%0t: result item expected none, got outcome %0d total_length %0d",
                   $time, out_w.outcome, out_w.total_length);
          fail_count++;
        end else begin
          head = pending_responses.pop_front();
          check_field("outcome", 32'(head.outcome), 32'(out_w.outcome));
          check_field("status_code", 32'(head.status_code), 32'(out_w.status_code));
          check_field("hdr_bytes", head.hdr_bytes, out_w.hdr_bytes);
          check_field("body_bytes", head.body_bytes, out_w.body_bytes);
          check_field("total_length", head.total_length, out_w.total_length);
        end
      end
      if (in_w.valid && in_w.ready) take_byte(in_w.data_byte, in_w.final_byte);
      pending_count = pending_responses.size();
    end
  end

endmodule

// File: tb/http_response_header_parser_test.sv
// Top of the header parser testbench: clock, reset, response byte stimulus and verdict.
`timescale 1ns / 1ps

module http_response_header_parser_test;
  import hrhp_pkg::*;

  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int BYTE_TARGET     = 1450;
  localparam int RESPONSE_TARGET = 40;
  localparam int DRAIN_CYCLES    = 8;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending_count;
  int   bytes_sent;
  int   responses_sent;
  int   idle_cycles;
  bit   tx_quiet;
  bit   rx_quiet;
  bit   hold_req;
  logic [7:0] msg[$];

  hrhp_in_if  in_ch ();
  hrhp_out_if out_ch ();

  http_response_header_parser #(.COUNT_BITS(32)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  http_response_header_parser_checker #(.COUNT_BITS(32)) response_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_w          (in_ch),
    .out_w         (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #2 clk_i = ~clk_i;

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
  endtask

  task automatic add_crlf();
    msg.push_back(CHAR_CR);
    msg.push_back(CHAR_LF);
  endtask

  task automatic add_line(input string s);
    add_text(s);
    add_crlf();
  endtask

  task automatic add_digits(input int n);
    repeat (n) msg.push_back(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
  endtask

  task automatic add_blanks();
    int n;
    int k;
    n = $urandom_range(1, 3);
    repeat (n) begin
      k = $urandom_range(0, 5);
      msg.push_back((k == 5) ? CHAR_SPACE : CHAR_TAB + 8'(k));
    end
  endtask

  task automatic put_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap(tx_quiet);
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.final_byte <= fin;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg.size(); i++) put_byte(msg[i], i == msg.size() - 1);
    bytes_sent += msg.size();
    responses_sent++;
    msg.delete();
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  task automatic compose_response();
    int         n;
    int         declared;
    int         body_len;
    string      kw;
    logic [7:0] c;
    kw = "content-length: ";
    if ($urandom_range(0, 99) < 6) begin
      n = $urandom_range(1, 20);
      repeat (n) msg.push_back(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 19))
      0: begin
        add_text("HTTP/1.1 ");
        msg[$urandom_range(0, PREFIX_LEN - 1)] = 8'($urandom_range(0, 255));
      end
      1: begin
        add_text("HTTP/1.");
        add_digits(1);
        add_text(" ");
      end
      default: begin
        if ($urandom_range(0, 1)) add_text("HTTP/1.1 ");
        else add_text("HTTP/1.0 ");
      end
    endcase
    if ($urandom_range(0, 7) == 0) add_blanks();
    case ($urandom_range(0, 9))
      0: msg.push_back(CHAR_PLUS);
      1: msg.push_back(CHAR_MINUS);
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: ;
      1: add_digits($urandom_range(5, 8));
      default: add_digits(3);
    endcase
    if ($urandom_range(0, 1)) add_line(" OK");
    else add_crlf();
    if ($urandom_range(0, 19) == 0) begin
      n = $urandom_range(1, MIN_LEN - 1);
      while (msg.size() > n) void'(msg.pop_back());
      return;
    end
    if ($urandom_range(0, 2) == 0) begin
      add_text("X-Id: ");
      add_digits($urandom_range(1, 3));
      add_crlf();
    end
    declared = 0;
    if ($urandom_range(0, 9) < 7) begin
      for (int i = 0; i < KW_LEN; i++) begin
        c = kw[i];
        if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
        msg.push_back(c);
      end
      if ($urandom_range(0, 9) == 0)
        msg[msg.size() - 1 - $urandom_range(0, KW_LEN - 1)] = 8'($urandom_range(33, 126));
      case ($urandom_range(0, 19))
        0: add_text("0");
        1: begin
          msg.push_back(CHAR_MINUS);
          add_digits($urandom_range(1, 2));
        end
        2: add_digits($urandom_range(10, 12));
        3: add_text("none");
        4: begin
          add_blanks();
          msg.push_back(CHAR_PLUS);
          declared = $urandom_range(1, 12);
          add_text($sformatf("%0d", declared));
        end
        default: begin
          declared = $urandom_range(1, 12);
          add_text($sformatf("%0d", declared));
        end
      endcase
      add_crlf();
    end
    case ($urandom_range(0, 19))
      0: ;
      1: begin
        msg.push_back(CHAR_CR);
        add_crlf();
        add_crlf();
      end
      default: add_crlf();
    endcase
    case ($urandom_range(0, 4))
      0: body_len = (declared > 0) ? $urandom_range(0, declared - 1) : $urandom_range(0, 4);
      1: body_len = declared + $urandom_range(1, 4);
      default: body_len = (declared > 0) ? declared : $urandom_range(0, 6);
    endcase
    if ($urandom_range(0, 9) == 0) add_text("Content-Length: 5");
    repeat (body_len) msg.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0)
      msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
  endtask

  initial begin : result_sink
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = pick_gap(rx_quiet);
      end
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int round;
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.final_byte = 1'b0;
    tx_quiet         = 1'b0;
    rx_quiet         = 1'b0;
    hold_req         = 1'b0;
    bytes_sent       = 0;
    responses_sent   = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    add_line("HTTP/1.1 200 OK"); add_line("Content-Length: 3"); add_crlf(); add_text("abc");
    send_message();
    add_line("HTTP/1.0 404"); add_crlf();
    send_message();
    add_line("HTTP/1.1 200"); add_line("cONTENT-lENGTH: 10"); add_crlf(); add_text("ab");
    send_message();
    add_text("HTTP/1.1 2");
    send_message();
    add_line("HTTX/1.1 200"); add_crlf();
    send_message();
    add_line("HTTP/1.1 200 OK");
    send_message();
    add_line("HTTP/1.1 9999999"); add_crlf();
    send_message();
    add_line("HTTP/1.1 -5"); add_crlf();
    send_message();
    add_text("HTTP/1.0 "); msg.push_back(CHAR_TAB); add_line(" +42x"); add_crlf();
    send_message();
    add_line("HTTP/1.1 200"); add_line("Content-Length: -1"); add_crlf(); add_text("z");
    send_message();
    add_line("HTTP/1.1 200"); add_line("Content-Length: 99999999999"); add_crlf();
    send_message();
    add_text("HTTP/1.1 200"); msg.push_back(8'h00); add_crlf(); add_crlf();
    msg.push_back(8'h00); msg.push_back(8'h00);
    send_message();
    add_line("HTTP/1.1 301"); add_line("Content-Length: 0"); add_crlf(); add_text("rest");
    send_message();
    add_line("HTTP/1.1 200"); add_line("Content-Length: x"); add_crlf();
    send_message();
    msg.push_back(8'hFF);
    send_message();
    add_text("HTTP/1.0 204"); msg.push_back(CHAR_CR); add_crlf(); add_crlf();
    send_message();
    add_text("HTTP/1.1 "); add_crlf(); add_crlf();
    send_message();
    add_line("HTTP/1.1 200"); add_crlf(); add_text("Content-Length: 2ab");
    send_message();

    round = 0;
    while (bytes_sent < BYTE_TARGET || responses_sent < RESPONSE_TARGET) begin
      if (round == 10) begin
        hold_req = 1'b1;
        tx_quiet = 1'b1;
        repeat (4) begin
          compose_response();
          send_message();
        end
        wait_for_results();
      end
      tx_quiet = ($urandom_range(0, 5) == 0);
      rx_quiet = ($urandom_range(0, 5) == 0);
      compose_response();
      send_message();
      round++;
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
hdl/hrhp_pkg.sv
hdl/hrhp_if.sv
hdl/hrhp_num_step.sv
hdl/http_response_header_parser.sv
tb/http_response_header_parser_checker.sv
tb/http_response_header_parser_test.sv
